FILE: sv/base64_mime_encoder_unit_macros.svh
// assertion macros for the base64 mime encoder checker
// expects clk and rst in the scope of use
`ifndef BASE64_MIME_ENCODER_UNIT_MACROS_SVH
`define BASE64_MIME_ENCODER_UNIT_MACROS_SVH

// same-cycle implication
`define B64ME_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("b64me check failed");

// next-cycle implication
`define B64ME_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("b64me check failed");

`endif

FILE: sv/b64me_pkg.sv
// types, constants and alphabet lookup for the base64 mime encoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package b64me_pkg;

  localparam logic [7:0] CHAR_CR  = 8'd13;
  localparam logic [7:0] CHAR_LF  = 8'd10;
  localparam logic [7:0] CHAR_PAD = 8'd61;

  localparam logic [5:0] GPL_RESET = 6'd19;

  localparam logic [2:0] IDX_CR = 3'd4;
  localparam logic [2:0] IDX_LF = 3'd5;

  // one request to the back end: four characters, optional line break
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic            crlf;
    logic            last;
  } job_t;

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] r;
    if (v < 6'd26) begin
      r = 8'd65 + {2'b00, v};
    end else if (v < 6'd52) begin
      r = 8'd71 + {2'b00, v};
    end else if (v < 6'd62) begin
      r = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      r = 8'd43;
    end else begin
      r = 8'd47;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: sv/b64me_front.sv
// front end: holds the byte group and line count, builds character requests
// depends on b64me_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64me_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [7:0]        byte_value,
  input  wire logic              last_byte,
  input  wire logic [5:0]        groups_per_line,
  output b64me_pkg::job_t        job,
  output logic                   job_push
);
  import b64me_pkg::*;

  logic [15:0] held_bytes, held_bytes_next;
  logic [1:0]  bytes_in_group, bytes_in_group_next;
  logic [5:0]  groups_on_line, groups_on_line_next;
  logic [5:0]  line_count;
  logic [23:0] word;
  logic [7:0]  b0;

  always_comb begin
    held_bytes_next     = held_bytes;
    bytes_in_group_next = bytes_in_group;
    groups_on_line_next = groups_on_line;
    job                 = '0;
    job.last            = last_byte;
    job_push            = 1'b0;
    word                = {held_bytes, byte_value};
    b0                  = held_bytes[7:0];
    line_count          = groups_on_line + 6'd1;
    if (bytes_in_group[1]) begin
      job_push     = 1'b1;
      job.chars[0] = sextet_char(word[23:18]);
      job.chars[1] = sextet_char(word[17:12]);
      job.chars[2] = sextet_char(word[11:6]);
      job.chars[3] = sextet_char(word[5:0]);
      held_bytes_next     = '0;
      bytes_in_group_next = '0;
      if (groups_per_line == 6'd0) begin
        groups_on_line_next = '0;
      end else if (line_count >= groups_per_line) begin
        job.crlf            = 1'b1;
        groups_on_line_next = '0;
      end else begin
        groups_on_line_next = line_count;
      end
    end else if (!last_byte) begin
      held_bytes_next     = {held_bytes[7:0], byte_value};
      bytes_in_group_next = bytes_in_group + 2'd1;
    end else if (bytes_in_group == 2'd0) begin
      job_push     = 1'b1;
      job.chars[0] = sextet_char(byte_value[7:2]);
      job.chars[1] = sextet_char({byte_value[1:0], 4'b0000});
      job.chars[2] = CHAR_PAD;
      job.chars[3] = CHAR_PAD;
    end else begin
      job_push     = 1'b1;
      job.chars[0] = sextet_char(b0[7:2]);
      job.chars[1] = sextet_char({b0[1:0], byte_value[7:4]});
      job.chars[2] = sextet_char({byte_value[3:0], 2'b00});
      job.chars[3] = CHAR_PAD;
    end
    if (last_byte) begin
      held_bytes_next     = '0;
      bytes_in_group_next = '0;
      groups_on_line_next = '0;
    end
    job_push = job_push & accept;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes     <= '0;
      bytes_in_group <= '0;
      groups_on_line <= '0;
    end else if (accept) begin
      held_bytes     <= held_bytes_next;
      bytes_in_group <= bytes_in_group_next;
      groups_on_line <= groups_on_line_next;
    end
  end

endmodule

`default_nettype wire

FILE: sv/b64me_queue.sv
// short request queue between front and back ends, depth 2 or more
// depends on b64me_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64me_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr_en,
  input  b64me_pkg::job_t        wr_data,
  input  wire logic              rd_en,
  output b64me_pkg::job_t        rd_data,
  output logic                   full,
  output logic                   empty
);
  import b64me_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr, do_rd;

  assign full    = (count == FULL_CNT);
  assign empty   = (count == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + PW'(1);
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: sv/b64me_back.sv
// back end: steps through the characters of each request into the output register
// depends on b64me_pkg
`timescale 1ns / 1ps
`default_nettype none

module b64me_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  b64me_pkg::job_t        job,
  input  wire logic              job_valid,
  output logic                   job_pop,
  input  wire logic              pop,
  output logic                   empty,
  output logic [7:0]             char_code,
  output logic                   run_last,
  output logic                   message_end
);
  import b64me_pkg::*;

  logic [2:0] idx, idx_next;
  logic       out_valid;
  logic       advance, load, final_char;
  logic [7:0] sel_char;

  assign empty      = ~out_valid;
  assign advance    = ~out_valid | pop;
  assign load       = advance & job_valid;
  assign final_char = job.crlf ? (idx == IDX_LF) : (idx == 3'd3);
  assign job_pop    = load & final_char;
  assign idx_next   = final_char ? 3'd0 : idx + 3'd1;

  always_comb begin
    case (idx)
      3'd0:    sel_char = job.chars[0];
      3'd1:    sel_char = job.chars[1];
      3'd2:    sel_char = job.chars[2];
      3'd3:    sel_char = job.chars[3];
      IDX_CR:  sel_char = CHAR_CR;
      IDX_LF:  sel_char = CHAR_LF;
      default: sel_char = CHAR_LF;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= job_valid;
      end
      if (load) begin
        idx <= idx_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      char_code   <= sel_char;
      run_last    <= final_char;
      message_end <= final_char & job.last;
    end
  end

endmodule

`default_nettype wire

FILE: sv/base64_mime_encoder_unit.sv
// base64 encoder with line breaks: a byte that completes or ends a group shows its
// first character on the ports via the queue slot and then the output register;
// characters leave the single output register at one per cycle while the receiver pops;
// a group gives 4 characters (6 with cr lf); rst (synchronous, active high) empties the
// queue, clears group and line state and sets groups_per_line to 19
`timescale 1ns / 1ps
`default_nettype none

module base64_mime_encoder_unit #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  byte_value,
  input  wire logic        last_byte,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       char_code,
  output logic             run_last,
  output logic             message_end,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import b64me_pkg::*;

  logic [5:0] groups_per_line;
  logic       accept;
  job_t       front_job, queue_job;
  logic       job_push, job_pop, queue_empty;

  assign pready = 1'b1;
  assign prdata = paddr[2] ? 32'd0 : {26'd0, groups_per_line};
  assign accept = push & ~full;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_per_line <= GPL_RESET;
    end else if (psel && penable && pwrite && pready && !paddr[2]) begin
      groups_per_line <= pwdata[5:0];
    end
  end

  b64me_front u_front (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .byte_value      (byte_value),
    .last_byte       (last_byte),
    .groups_per_line (groups_per_line),
    .job             (front_job),
    .job_push        (job_push)
  );

  b64me_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_data (front_job),
    .rd_en   (job_pop),
    .rd_data (queue_job),
    .full    (full),
    .empty   (queue_empty)
  );

  b64me_back u_back (
    .clk         (clk),
    .rst         (rst),
    .job         (queue_job),
    .job_valid   (~queue_empty),
    .job_pop     (job_pop),
    .pop         (pop),
    .empty       (empty),
    .char_code   (char_code),
    .run_last    (run_last),
    .message_end (message_end)
  );

endmodule

`default_nettype wire

FILE: sv/b64me_checker.sv
// port-level checks for the base64 mime encoder, bound to the top level
// depends on base64_mime_encoder_unit_macros.svh and b64me_pkg
`timescale 1ns / 1ps
`default_nettype none
`include "base64_mime_encoder_unit_macros.svh"

module b64me_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] char_code,
  input wire logic       run_last,
  input wire logic       message_end,
  input wire logic       pready
);
  import b64me_pkg::*;

  // a message end closes the request that caused it
  `B64ME_ASSERT_NOW(a_end_is_run_last, !empty && message_end, run_last)

  // lf always follows a taken cr
  `B64ME_ASSERT_NEXT(a_cr_then_lf, !empty && pop && char_code == CHAR_CR,
                     !empty && char_code == CHAR_LF && run_last)

  // a waiting result holds while not taken
  `B64ME_ASSERT_NEXT(a_hold_on_stall, !empty && !pop, !empty && $stable(char_code))

  `B64ME_ASSERT_NOW(a_pready_high, 1'b1, pready)

  `B64ME_ASSERT_NOW(a_empty_after_reset, $past(rst), empty)

endmodule

bind base64_mime_encoder_unit b64me_checker u_b64me_checker (
  .clk         (clk),
  .rst         (rst),
  .empty       (empty),
  .pop         (pop),
  .char_code   (char_code),
  .run_last    (run_last),
  .message_end (message_end),
  .pready      (pready)
);

`default_nettype wire

FILE: dv/base64_mime_encoder_unit_tb.sv
// testbench for base64_mime_encoder_unit: directed and random byte streams
// checked against a local model of the encoder; depends on b64me_pkg and the dut
`timescale 1ns / 1ps

module base64_mime_encoder_unit_tb;
  import b64me_pkg::*;

  localparam logic [2:0] GPL_ADDR   = 3'd0;
  localparam logic [2:0] SPARE_ADDR = 3'd4;
  localparam logic [8*64-1:0] ALPHABET =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  typedef struct {
    logic [7:0] code;
    logic       run_last;
    logic       msg_end;
  } char_rec_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  byte_value = 8'd0;
  logic        last_byte = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic [7:0]  char_code;
  logic        run_last;
  logic        message_end;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  // encoder model state
  logic [5:0]  line_len = GPL_RESET;
  logic [15:0] held = 16'd0;
  logic [1:0]  held_count = 2'd0;
  logic [5:0]  line_groups = 6'd0;

  char_rec_t   expected_chars[$];
  int          fail_count = 0;

  // sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int max_gap = 0;
  int max_burst = 8;
  int stall_pct = 0;
  int stall_left = 0;

  base64_mime_encoder_unit dut (
    .clk(clk), .rst(rst),
    .push(push), .full(full), .byte_value(byte_value), .last_byte(last_byte),
    .empty(empty), .pop(pop), .char_code(char_code), .run_last(run_last),
    .message_end(message_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #4 clk = ~clk;

  function automatic logic [7:0] b64_char(input logic [5:0] v);
    return ALPHABET[8*(63 - v) +: 8];
  endfunction

  task automatic predict_byte(input logic [7:0] b, input logic last);
    logic [7:0]  chars[$];
    logic [23:0] word;
    logic [7:0]  b0;
    logic [5:0]  g;
    char_rec_t   rec;
    if (held_count == 2'd2) begin
      word = {held, b};
      for (int k = 3; k >= 0; k--) chars.push_back(b64_char(word[6*k +: 6]));
      held = 16'd0;
      held_count = 2'd0;
      if (line_len != 6'd0) begin
        g = line_groups + 6'd1;
        if (g >= line_len) begin
          chars.push_back(CHAR_CR);
          chars.push_back(CHAR_LF);
          g = 6'd0;
        end
        line_groups = g;
      end else begin
        line_groups = 6'd0;
      end
    end else if (!last) begin
      held = {held[7:0], b};
      held_count = held_count + 2'd1;
      return;
    end else if (held_count == 2'd0) begin
      chars.push_back(b64_char(b[7:2]));
      chars.push_back(b64_char({b[1:0], 4'b0000}));
      chars.push_back(CHAR_PAD);
      chars.push_back(CHAR_PAD);
    end else begin
      b0 = held[7:0];
      chars.push_back(b64_char(b0[7:2]));
      chars.push_back(b64_char({b0[1:0], b[7:4]}));
      chars.push_back(b64_char({b[3:0], 2'b00}));
      chars.push_back(CHAR_PAD);
    end
    foreach (chars[i]) begin
      rec.code = chars[i];
      rec.run_last = (i == chars.size() - 1);
      rec.msg_end = last && (i == chars.size() - 1);
      expected_chars.push_back(rec);
    end
    if (last) begin
      held = 16'd0;
      held_count = 2'd0;
      line_groups = 6'd0;
    end
  endtask

  // one byte request, paced in bursts with gaps
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, max_burst);
      gap_left = $urandom_range(0, max_gap);
    end
    @(negedge clk);
    while (gap_left > 0) begin
      push <= 1'b0;
      gap_left--;
      @(negedge clk);
    end
    push <= 1'b1;
    byte_value <= b;
    last_byte <= last;
    do @(posedge clk); while (full !== 1'b0);
    predict_byte(b, last);
    burst_left--;
  endtask

  // stop sending and wait for every expected character
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (addr == GPL_ADDR) line_len = data[5:0];
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_check();
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= GPL_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    if (prdata !== {26'd0, line_len}) begin
      $error("groups_per_line: expected %0d, actual %0d", line_len, prdata);
      fail_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_bytes(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_byte(bytes[i], i == bytes.size() - 1);
  endtask

  task automatic test_reset_values();
    cfg_check();
    max_gap = 3;
    stall_pct = 20;
    // crosses the default line length
    for (int i = 0; i < 62; i++) send_byte(8'($urandom_range(0, 255)), i == 61);
    settle();
  endtask

  task automatic test_padding();
    max_gap = 0;
    stall_pct = 0;
    send_bytes('{8'h00});
    send_bytes('{8'hFF});
    send_bytes('{8'hFF, 8'h00});
    send_bytes('{8'h00, 8'hFF});
    settle();
  endtask

  task automatic test_alphabet_edges();
    max_gap = 2;
    stall_pct = 30;
    send_bytes('{8'hFB, 8'hFF, 8'hBF});
    send_bytes('{8'h00, 8'h00, 8'h00});
    settle();
  endtask

  task automatic test_break_every_group();
    cfg_write(GPL_ADDR, 32'd1);
    cfg_check();
    max_gap = 1;
    stall_pct = 10;
    send_bytes('{8'h12, 8'h34, 8'h56, 8'hAB, 8'hCD, 8'hEF});
    settle();
  endtask

  task automatic test_line_shortened();
    cfg_write(GPL_ADDR, 32'd19);
    max_gap = 0;
    stall_pct = 0;
    for (int i = 0; i < 9; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    settle();
    // line already longer than the new setting
    cfg_write(GPL_ADDR, 32'd2);
    for (int i = 0; i < 3; i++) send_byte(8'($urandom_range(0, 255)), 1'b0);
    send_byte(8'($urandom_range(0, 255)), 1'b1);
    settle();
  endtask

  task automatic test_register_decode();
    cfg_write(SPARE_ADDR, 32'd7);
    cfg_check();
    cfg_write(GPL_ADDR, 32'hFFFF_FFC5);
    cfg_check();
    send_bytes('{8'h5A, 8'hA5, 8'h3C, 8'hC3, 8'h0F, 8'hF0, 8'h81});
    settle();
  endtask

  task automatic test_random_phase(input logic [31:0] gpl, input int nbytes,
                                   input int max_msg, input int gap, input int stall);
    int sent;
    int len;
    cfg_write(GPL_ADDR, gpl);
    cfg_check();
    max_gap = gap;
    stall_pct = stall;
    sent = 0;
    while (sent < nbytes) begin
      len = $urandom_range(1, max_msg);
      if (sent + len > nbytes) len = nbytes - sent;
      for (int i = 0; i < len; i++) send_byte(8'($urandom_range(0, 255)), i == len - 1);
      sent += len;
      if ($urandom_range(0, 7) == 0) settle();
    end
    settle();
  endtask

  // receiver stalls on its own pattern
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else if (stall_left > 0) begin
      pop <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      pop <= 1'b1;
      if ($urandom_range(1, 100) <= stall_pct) stall_left <= $urandom_range(1, 8);
    end
  end

  always @(posedge clk) begin
    char_rec_t want;
    if (!rst && pop && !empty) begin
      if (expected_chars.size() == 0) begin
        $error("char_code: expected none, actual %0d", char_code);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (char_code !== want.code) begin
          $error("char_code: expected %0d, actual %0d", want.code, char_code);
          fail_count++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0d, actual %0d", want.run_last, run_last);
          fail_count++;
        end
        if (message_end !== want.msg_end) begin
          $error("message_end: expected %0d, actual %0d", want.msg_end, message_end);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("base64_mime_encoder_unit_tb: FAIL");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);
    test_reset_values();
    test_padding();
    test_alphabet_edges();
    test_break_every_group();
    test_line_shortened();
    test_register_decode();
    test_random_phase(32'd0, 30, 12, 2, 20);
    test_random_phase(32'd1, 30, 12, 0, 0);
    test_random_phase(32'd63, 100, 100, 1, 15);
    test_random_phase($urandom_range(2, 62), 30, 40, 4, 40);
    test_random_phase(32'd19, 30, 20, 3, 50);
    settle();
    if (fail_count == 0) begin
      $display("base64_mime_encoder_unit_tb: PASS");
    end else begin
      $display("base64_mime_encoder_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: base64_mime_encoder_unit.f
+incdir+sv
sv/b64me_pkg.sv
sv/b64me_front.sv
sv/b64me_queue.sv
sv/b64me_back.sv
sv/base64_mime_encoder_unit.sv
sv/b64me_checker.sv
dv/base64_mime_encoder_unit_tb.sv
